// ===== sv/vgd_pkg.sv =====
// Package for the 2D voxel-grid downsampler.
// Holds the fixed field widths and rounding constants; no dependencies.
package vgd_pkg;

  // Field and datapath widths.
  localparam int COORD_W = 20;
  localparam int RES_W   = 17;
  localparam int MUL_W   = 21;
  localparam int KEY_W   = 42;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 7;
  localparam int STEP_W  = 5;

  // Largest legal inverse resolution (1.0 in Q16).
  localparam logic [RES_W-1:0] RES_MAX   = 17'd65536;
  localparam logic [RES_W-1:0] RES_RESET = 17'd3277;

  // Rounding offsets for the Q16 products.
  localparam logic [KEY_W-1:0] HALF_Q16 = 42'h0_8000;
  localparam logic [KEY_W-1:0] CEIL_Q16 = 42'h0_FFFF;

  // Register indexes on the configuration port.
  localparam logic REG_INV_RES_X = 1'b0;
  localparam logic REG_INV_RES_Y = 1'b1;

endpackage

// ===== sv/voxel_grid_downsample_2d.sv =====
// Operation: points are loaded first. After the last point a cell pass
// computes one key per point, then each output group takes one scan of
// the stored points and two divisions, x then y, before it is shown.
// Throughput: one point per cycle while loading; the shared multiplier and
// the bit-serial divider set the post-load time. Reset is synchronous and
// clears control state and the configuration registers to 3277.
module voxel_grid_downsample_2d import vgd_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  // Point input channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      last_point,
  // Result output channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] mean_x,
  output logic signed [COORD_W-1:0] mean_y,
  output logic                      last_result,
  // Configuration port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int AW = $clog2(MAX_POINTS);

  // Sequencer codes.
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_COLS0 = 4'd1;
  localparam logic [3:0] S_COLS1 = 4'd2;
  localparam logic [3:0] S_K0    = 4'd3;
  localparam logic [3:0] S_K1    = 4'd4;
  localparam logic [3:0] S_K2    = 4'd5;
  localparam logic [3:0] S_K3    = 4'd6;
  localparam logic [3:0] S_K4    = 4'd7;
  localparam logic [3:0] S_K5    = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_DXS   = 4'd10;
  localparam logic [3:0] S_DXW   = 4'd11;
  localparam logic [3:0] S_DYS   = 4'd12;
  localparam logic [3:0] S_DYW   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state;

  // Configuration registers.
  logic [RES_W-1:0] inv_res_x;
  logic [RES_W-1:0] inv_res_y;
  logic [RES_W-1:0] cfg_clamped;
  logic             cfg_write;

  // Point stores and key store.
  logic signed [COORD_W-1:0] store_x [MAX_POINTS];
  logic signed [COORD_W-1:0] store_y [MAX_POINTS];
  logic [KEY_W-1:0]          cell_keys [MAX_POINTS];
  logic signed [COORD_W-1:0] xq;
  logic signed [COORD_W-1:0] yq;
  logic [KEY_W-1:0]          kq;
  logic [AW-1:0]             rd_addr;
  logic                      rd_en;

  // Cloud state.
  logic [CNT_W-1:0]          loaded_count;
  logic signed [COORD_W-1:0] low_x;
  logic signed [COORD_W-1:0] low_y;
  logic signed [COORD_W-1:0] high_x;
  logic                      in_accept;

  // Cell pass registers.
  logic [MUL_W-1:0] cols;
  logic [MUL_W-1:0] cx;
  logic [MUL_W-1:0] cy;
  logic [CNT_W-1:0] kidx;
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [KEY_W-1:0] mul_p;
  logic [KEY_W-1:0] p_half;
  logic [KEY_W-1:0] p_ceil;
  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic [COORD_W:0] dspan;

  // Scan and group registers.
  logic [CNT_W-1:0]        sidx;
  logic                    s_vld;
  logic                    found;
  logic [KEY_W-1:0]        best;
  logic                    have_bound;
  logic [KEY_W-1:0]        bound;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        emitted;
  logic                    eligible;

  // Divider hookup.
  logic                      div_start;
  logic signed [SUM_W-1:0]   div_dividend;
  logic                      div_done;
  logic signed [COORD_W-1:0] div_quot;

  // APB-style configuration access with a clamp to the legal range.
  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign cfg_clamped = (pwdata[RES_W-1:0] > RES_MAX) ? RES_MAX : pwdata[RES_W-1:0];
  assign prdata      = (paddr[2] == REG_INV_RES_Y) ? 32'(inv_res_y) : 32'(inv_res_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_res_x <= RES_RESET;
      inv_res_y <= RES_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_INV_RES_X: inv_res_x <= cfg_clamped;
        REG_INV_RES_Y: inv_res_y <= cfg_clamped;
        default:       inv_res_x <= inv_res_x;
      endcase
    end
  end

  // Input request is taken only while loading.
  assign in_ready  = (state == S_LOAD);
  assign in_accept = in_valid && in_ready;

  // Point memories: written while loading, read by the cell pass and scans.
  always_ff @(posedge clk) begin
    if (in_accept && (loaded_count < CNT_W'(MAX_POINTS))) begin
      store_x[loaded_count[AW-1:0]] <= point_x;
      store_y[loaded_count[AW-1:0]] <= point_y;
    end
    if (rd_en) begin
      xq <= store_x[rd_addr];
      yq <= store_y[rd_addr];
    end
  end

  // Key memory: written once per point in the cell pass.
  always_ff @(posedge clk) begin
    if (state == S_K5) begin
      cell_keys[kidx[AW-1:0]] <= mul_p + KEY_W'(cx);
    end
    if (rd_en) begin
      kq <= cell_keys[rd_addr];
    end
  end

  // Read address: the cell pass and the scans share the read port.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = kidx[AW-1:0];
    if (state == S_K0) begin
      rd_en = 1'b1;
    end else if ((state == S_SCAN) && (sidx < loaded_count)) begin
      rd_en   = 1'b1;
      rd_addr = sidx[AW-1:0];
    end
  end

  // Offsets from the box minimum are never negative.
  assign dx     = {xq[COORD_W-1], xq} - {low_x[COORD_W-1], low_x};
  assign dy     = {yq[COORD_W-1], yq} - {low_y[COORD_W-1], low_y};
  assign dspan  = {high_x[COORD_W-1], high_x} - {low_x[COORD_W-1], low_x};
  assign p_half = mul_p + HALF_Q16;
  assign p_ceil = mul_p + CEIL_Q16;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = dspan;
    mul_b = MUL_W'(inv_res_x);
    unique case (state)
      S_K1: begin
        mul_a = dx;
        mul_b = MUL_W'(inv_res_x);
      end
      S_K2: begin
        mul_a = dy;
        mul_b = MUL_W'(inv_res_y);
      end
      S_K4: begin
        mul_a = cy;
        mul_b = cols;
      end
      default: begin
        mul_a = dspan;
        mul_b = MUL_W'(inv_res_x);
      end
    endcase
  end

  vgd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Divider operand follows the axis being worked on.
  assign div_start    = (state == S_DXS) || (state == S_DYS);
  assign div_dividend = (state == S_DYS) ? sum_y : sum_x;

  vgd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt),
    .done     (div_done),
    .quot     (div_quot)
  );

  // An entry joins the scan only if its key lies below the last group.
  assign eligible = !have_bound || (kq < bound);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      loaded_count <= '0;
      low_x        <= '0;
      low_y        <= '0;
      high_x       <= '0;
      out_valid    <= 1'b0;
      s_vld        <= 1'b0;
      found        <= 1'b0;
      have_bound   <= 1'b0;
      kidx         <= '0;
      sidx         <= '0;
      emitted      <= '0;
    end else begin
      unique case (state)
        // Take points and track the bounding box.
        S_LOAD: begin
          if (in_accept) begin
            if (loaded_count == '0) begin
              low_x  <= point_x;
              low_y  <= point_y;
              high_x <= point_x;
            end else if (loaded_count < CNT_W'(MAX_POINTS)) begin
              if (point_x < low_x)  low_x  <= point_x;
              if (point_y < low_y)  low_y  <= point_y;
              if (point_x > high_x) high_x <= point_x;
            end
            if (loaded_count < CNT_W'(MAX_POINTS)) begin
              loaded_count <= loaded_count + 1'b1;
            end
            if (last_point) begin
              if (loaded_count == '0) begin
                // A cloud of one point passes straight through.
                mean_x      <= point_x;
                mean_y      <= point_y;
                last_result <= 1'b1;
                out_valid   <= 1'b1;
                state       <= S_OUT;
              end else begin
                state <= S_COLS0;
              end
            end
          end
        end
        S_COLS0: begin
          state <= S_COLS1;
        end
        S_COLS1: begin
          cols  <= p_ceil[36:16];
          kidx  <= '0;
          state <= S_K0;
        end
        // Per-point cell key: x cell, y cell, then row times columns.
        S_K0: state <= S_K1;
        S_K1: state <= S_K2;
        S_K2: begin
          cx    <= p_half[36:16];
          state <= S_K3;
        end
        S_K3: begin
          cy    <= p_half[36:16];
          state <= S_K4;
        end
        S_K4: state <= S_K5;
        S_K5: begin
          kidx <= kidx + 1'b1;
          if (kidx == loaded_count - 1'b1) begin
            sidx       <= '0;
            s_vld      <= 1'b0;
            found      <= 1'b0;
            have_bound <= 1'b0;
            emitted    <= '0;
            state      <= S_SCAN;
          end else begin
            state <= S_K0;
          end
        end
        // Find the largest key below the bound and sum its points.
        S_SCAN: begin
          s_vld <= rd_en;
          if (rd_en) begin
            sidx <= sidx + 1'b1;
          end
          if (s_vld && eligible) begin
            if (!found || (kq > best)) begin
              found <= 1'b1;
              best  <= kq;
              sum_x <= SUM_W'(xq);
              sum_y <= SUM_W'(yq);
              cnt   <= CNT_W'(1);
            end else if (kq == best) begin
              sum_x <= sum_x + SUM_W'(xq);
              sum_y <= sum_y + SUM_W'(yq);
              cnt   <= cnt + 1'b1;
            end
          end
          if (!s_vld && !rd_en && (sidx == loaded_count)) begin
            state <= S_DXS;
          end
        end
        S_DXS: state <= S_DXW;
        S_DXW: begin
          if (div_done) begin
            mean_x <= div_quot;
            state  <= S_DYS;
          end
        end
        S_DYS: state <= S_DYW;
        S_DYW: begin
          if (div_done) begin
            mean_y      <= div_quot;
            last_result <= (emitted + cnt == loaded_count);
            emitted     <= emitted + cnt;
            bound       <= best;
            have_bound  <= 1'b1;
            out_valid   <= 1'b1;
            state       <= S_OUT;
          end
        end
        // Hold the result until it is taken.
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_result) begin
              loaded_count <= '0;
              emitted      <= '0;
              state        <= S_LOAD;
            end else begin
              sidx  <= '0;
              s_vld <= 1'b0;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Loading and showing a result never overlap.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while a result is shown");
  // A group handed to the divider always holds at least one point.
  assert property (@(posedge clk) disable iff (rst) (state == S_DXS) |-> (cnt != '0))
    else $error("empty group reached the divider");
  // Groups never account for more points than were loaded.
  assert property (@(posedge clk) disable iff (rst) (state == S_OUT) |-> (emitted <= loaded_count))
    else $error("more points emitted than loaded");
  // The divider only finishes while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == S_DXW) || (state == S_DYW)))
    else $error("divider finished outside a wait state");
`endif

endmodule

// ===== sv/vgd_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on vgd_pkg for the operand and product widths.
module vgd_mul import vgd_pkg::*; (
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [KEY_W-1:0]   p
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    p <= KEY_W'(a) * KEY_W'(b);
  end

endmodule

// ===== sv/vgd_div.sv =====
// Restoring divider, one quotient bit per cycle, signed sum by point count.
// Depends on vgd_pkg for widths; the quotient is truncated toward zero.
module vgd_div import vgd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic signed [COORD_W-1:0] quot
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;
  logic [SUM_W-1:0]  signed_q;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {rem, mag[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // Control: run SUM_W steps after a start, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude register doubles as the quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      mag <= {mag[SUM_W-2:0], fits};
    end
  end

  // Restore the sign and keep the coordinate bits.
  assign signed_q = neg ? (~mag + 1'b1) : mag;
  assign quot     = signed_q[COORD_W-1:0];

endmodule

// ===== sim/voxel_grid_downsample_2d_checker.sv =====
// Checker for the 2D voxel-grid downsampler: watches the point and result
// channels and the configuration port, predicts cell means and compares them.
// Depends on vgd_pkg for field widths and register indexes.
`timescale 1ns / 100ps
module voxel_grid_downsample_2d_checker import vgd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic                      last_point,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COORD_W-1:0] mean_x,
  input  logic signed [COORD_W-1:0] mean_y,
  input  logic                      last_result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  input  logic                      pready,
  output int                        mismatches,
  output int                        pending
);

  typedef struct packed {
    logic signed [COORD_W-1:0] mx;
    logic signed [COORD_W-1:0] my;
    logic                      lst;
  } mean_t;

  localparam int DEPTH = 64;

  mean_t           mean_queue[$];
  logic [RES_W-1:0] res_x, res_y;
  longint          cloud_x[DEPTH];
  longint          cloud_y[DEPTH];
  int              cloud_n;
  longint          box_lo_x, box_lo_y, box_hi_x;

  assign pending = mean_queue.size();

  function automatic longint grid_cell(longint p, longint lo, longint inv);
    return ((p - lo) * inv + 32768) >>> 16;
  endfunction

  // Sort the cloud by cell key, descending and stable, then queue group means.
  task automatic predict_means();
    longint keys[DEPTH];
    int     ids[DEPTH];
    longint cols, k, sx, sy, cnt;
    int     i, j;
    mean_t  m;
    if (cloud_n <= 1) begin
      m.mx = COORD_W'(cloud_x[0]);
      m.my = COORD_W'(cloud_y[0]);
      m.lst = 1'b1;
      mean_queue.insert(mean_queue.size(), m);
      return;
    end
    cols = ((box_hi_x - box_lo_x) * longint'(res_x) + 65535) >>> 16;
    for (i = 0; i < cloud_n; i++) begin
      k = grid_cell(cloud_y[i], box_lo_y, longint'(res_y)) * cols
        + grid_cell(cloud_x[i], box_lo_x, longint'(res_x));
      j = i;
      while (j > 0 && keys[j-1] < k) begin
        keys[j] = keys[j-1];
        ids[j] = ids[j-1];
        j--;
      end
      keys[j] = k;
      ids[j] = i;
    end
    sx = 0; sy = 0; cnt = 0;
    for (i = 0; i < cloud_n; i++) begin
      sx += cloud_x[ids[i]];
      sy += cloud_y[ids[i]];
      cnt++;
      if (i == cloud_n - 1 || keys[i+1] != keys[i]) begin
        m.mx = COORD_W'(sx / cnt);
        m.my = COORD_W'(sy / cnt);
        m.lst = (i == cloud_n - 1);
        mean_queue.insert(mean_queue.size(), m);
        sx = 0; sy = 0; cnt = 0;
      end
    end
  endtask

  // Track register writes, accepted requests and delivered means.
  always @(posedge clk) begin
    logic [31:0] v;
    mean_t       want;
    if (rst) begin
      res_x <= RES_RESET;
      res_y <= RES_RESET;
      cloud_n = 0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        v = pwdata & 32'h1FFFF;
        if (v > 32'(RES_MAX)) v = 32'(RES_MAX);
        if (paddr[2] == REG_INV_RES_X) res_x <= v[RES_W-1:0];
        else res_y <= v[RES_W-1:0];
      end
      if (in_valid && in_ready) begin
        if (cloud_n < DEPTH) begin
          if (cloud_n == 0) begin
            box_lo_x = point_x; box_lo_y = point_y; box_hi_x = point_x;
          end else begin
            if (point_x < box_lo_x) box_lo_x = point_x;
            if (point_y < box_lo_y) box_lo_y = point_y;
            if (point_x > box_hi_x) box_hi_x = point_x;
          end
          cloud_x[cloud_n] = point_x;
          cloud_y[cloud_n] = point_y;
          cloud_n++;
        end
        if (last_point) begin
          predict_means();
          cloud_n = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (mean_queue.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected mean x=%0d y=%0d last=%0b", mean_x, mean_y, last_result);
          mismatches <= mismatches + 1;
        end else begin
          want = mean_queue.pop_front();
          if (want.mx !== mean_x || want.my !== mean_y || want.lst !== last_result) begin
            if (mismatches < 10)
              $display("mean mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       want.mx, want.my, want.lst, mean_x, mean_y, last_result);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/voxel_grid_downsample_2d_test.sv =====
// Testbench top for the 2D voxel-grid downsampler: drives point clouds and
// register writes, and gives the verdict. Depends on vgd_pkg and the checker.
`timescale 1ns / 100ps
module voxel_grid_downsample_2d_test;
  import vgd_pkg::*;

  logic                      clk, rst;
  logic                      in_valid, in_ready, out_valid, out_ready;
  logic signed [COORD_W-1:0] point_x, point_y, mean_x, mean_y;
  logic                      last_point, last_result;
  logic                      psel, penable, pwrite, pready;
  logic [2:0]                paddr;
  logic [31:0]               pwdata, prdata;
  int                        mismatches, pending;
  bit                        hold_long;

  voxel_grid_downsample_2d DUT (.*);
  voxel_grid_downsample_2d_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stalls, with one long hold-off while requests keep coming.
  initial begin
    int w;
    out_ready = 0;
    @(posedge clk);
    while (!rst) @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // Offer one point request and wait until it is taken.
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic lst,
                            input bit gaps);
    int w;
    w = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1; point_x <= x; point_y <= y; last_point <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random cloud; points cluster around a center so cells share means, or are uniform for a negative spread.
  task automatic send_cloud(input int n, input int spread, input bit gaps);
    int cx, cy;
    cx = $urandom_range(0, 1048575) - 524288;
    cy = $urandom_range(0, 1048575) - 524288;
    if (spread < 0) cx = 0;
    for (int i = 0; i < n; i++) begin
      if (spread < 0)
        send_point(COORD_W'($urandom), COORD_W'($urandom), i == n - 1, gaps);
      else
        send_point(COORD_W'(cx + $signed($urandom_range(0, 2 * spread)) - spread),
                   COORD_W'(cy + $signed($urandom_range(0, 2 * spread)) - spread),
                   i == n - 1, gaps);
    end
    in_valid <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (2000) @(posedge clk);
  endtask

  initial begin
    rst = 1; in_valid = 0; point_x = 0; point_y = 0; last_point = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    hold_long = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single points at the extremes and at the origin.
    send_point(20'sh80000, 20'sh7FFFF, 1'b1, 1'b0);
    send_point(20'sh7FFFF, 20'sh80000, 1'b1, 1'b0);
    send_point(20'sd0, 20'sd0, 1'b1, 1'b1);
    // Two points at opposite corners, then duplicates in one cell.
    send_point(20'sh80000, 20'sh80000, 1'b0, 1'b0);
    send_point(20'sh7FFFF, 20'sh7FFFF, 1'b1, 1'b0);
    send_point(-20'sd7, 20'sd3, 1'b0, 1'b1);
    send_point(-20'sd7, 20'sd3, 1'b0, 1'b1);
    send_point(-20'sd8, 20'sd2, 1'b1, 1'b1);
    // Rounding edge: offsets near half a cell.
    send_point(20'sd0, 20'sd0, 1'b0, 1'b0);
    send_point(20'sd10, 20'sd0, 1'b0, 1'b0);
    send_point(20'sd30, 20'sd10, 1'b1, 1'b0);
    in_valid <= 0;
    drain();

    // Zero resolution collapses the cloud; over-range values clamp.
    write_reg(REG_INV_RES_X, 0);
    write_reg(REG_INV_RES_Y, 0);
    send_cloud(5, 1000, 1'b1);
    drain();
    write_reg(REG_INV_RES_X, 32'hFFFFFFFF);
    write_reg(REG_INV_RES_Y, 32'h1FFFF);
    send_cloud(6, 3, 1'b1);
    drain();

    // Overfull store: more than 64 points, long receiver hold-off.
    write_reg(REG_INV_RES_X, 65536);
    write_reg(REG_INV_RES_Y, 1);
    hold_long = 1;
    send_cloud(70, 40, 1'b0);
    send_cloud(8, 40, 1'b0);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_INV_RES_X, $urandom_range(1, 65536));
      write_reg(REG_INV_RES_Y, (ph == 3) ? 1 : $urandom_range(1, 65536));
      for (int c = 0; c < 3; c++)
        send_cloud($urandom_range(1, 12), (c == 2) ? -1 : $urandom_range(1, 4000), 1'b1);
      drain();
    end

    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== voxel_grid_downsample_2d.f =====
sv/vgd_pkg.sv
sv/vgd_mul.sv
sv/vgd_div.sv
sv/voxel_grid_downsample_2d.sv
sim/voxel_grid_downsample_2d_checker.sv
sim/voxel_grid_downsample_2d_test.sv
